// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers; they compile to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DLA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define DLA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define DLA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DLA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/dla_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DLA package
// Widths, operation, status and step codes for the aggregation walker.
// ---------------------------------------------------------------------------
package dla_pkg;

    localparam int MAX_SIDE_DEF = 256;  // default grid side limit
    localparam int SIDE_LIMIT   = 256;  // coordinates are 8 bits
    localparam int COORD_W      = 8;
    localparam int SIZE_W       = 9;
    localparam int OP_W         = 2;
    localparam int STEP_W       = 2;
    localparam int STAT_W       = 2;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 9'd256;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_LAUNCH = 2'd1;
    localparam logic [OP_W-1:0] OP_MOVE   = 2'd2;

    localparam logic [STEP_W-1:0] STEP_BACK = 2'd0;
    localparam logic [STEP_W-1:0] STEP_STAY = 2'd1;

    localparam logic [STAT_W-1:0] STAT_WALK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_STUCK  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_CLEAR  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_IGNORE = 2'd3;

endpackage

// ----- rtl/dla_walker_grid_step.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// DLA walker grid step
// Occupancy bitmap on a torus plus one random walker: clear/seed, launch,
// move, and stick-on-contact deposit.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------
//  in word  | i_valid / o_ready           | i_operation, i_launch_row/col,
//           |                             | i_row_step, i_col_step
//  out word | o_valid / i_ready           | o_status, o_row, o_col
//  config   | i_cfg_wr_en (no wait)       | i_cfg_wr_data (grid_size)
//
//  Launch or move: accept, then reads of the row above, the row
//    below and the walker's own row from the grid RAM, then decide/write.
//  Move of a walker left outside a shrunken grid: first an 8-step
//    remainder fold, then the shift.
//  Clear: accept, one RAM row written per cycle, then report;
//    ignored word: accept, then report.
//  Reset: a clearing pass over all SIDE_CAP rows (256 by default), o_ready low.
//  A stalled out word holds the block in its decide step; one word is
//    buffered, so the next in word is taken while it waits.
// ---------------------------------------------------------------------------
module dla_walker_grid_step
    import dla_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config
    input  logic                i_cfg_wr_en,
    input  logic [SIZE_W-1:0]   i_cfg_wr_data,
    // in word
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [COORD_W-1:0]  i_launch_row,
    input  logic [COORD_W-1:0]  i_launch_col,
    input  logic [STEP_W-1:0]   i_row_step,
    input  logic [STEP_W-1:0]   i_col_step,
    // out word
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STAT_W-1:0]   o_status,
    output logic [COORD_W-1:0]  o_row,
    output logic [COORD_W-1:0]  o_col
);

    // Rows and columns actually reachable: coordinates never pass 255.
    localparam int SIDE_CAP = (MAX_SIDE < SIDE_LIMIT) ? MAX_SIDE : SIDE_LIMIT;
    localparam int AW       = $clog2(SIDE_CAP);
    localparam logic [AW-1:0]     LAST_ROW  = AW'(SIDE_CAP - 1);
    localparam logic [SIZE_W-1:0] CAP_S     = SIZE_W'(SIDE_CAP);
    localparam logic [SIZE_W-1:0] MIN_S     = SIZE_W'(3);
    localparam logic [2:0]        FOLD_LAST = 3'(COORD_W - 1);

    // FSM codes
    localparam logic [2:0] S_SWEEP  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_FOLD   = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_RD_DN  = 3'd4;
    localparam logic [2:0] S_RD_OWN = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;

    // what the decide step reports
    localparam logic [1:0] KIND_SETTLE = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_IGNORE = 2'd2;

    // -----------------------------------------------------------------------
    // Torus helpers
    // -----------------------------------------------------------------------
    function automatic logic [COORD_W-1:0] wrap_dec(input logic [COORD_W-1:0] p,
                                                    input logic [SIZE_W-1:0]  s);
        logic [SIZE_W-1:0] t;
        t = (p == '0) ? s - SIZE_W'(1) : {1'b0, p} - SIZE_W'(1);
        return t[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] p,
                                                    input logic [SIZE_W-1:0]  s);
        logic [SIZE_W-1:0] t;
        t = ({1'b0, p} == s - SIZE_W'(1)) ? '0 : {1'b0, p} + SIZE_W'(1);
        return t[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] step_pos(input logic [COORD_W-1:0] p,
                                                    input logic [STEP_W-1:0]  st,
                                                    input logic [SIZE_W-1:0]  s);
        logic [COORD_W-1:0] q;
        unique case (st)
            STEP_BACK: q = wrap_dec(p, s);
            STEP_STAY: q = p;
            default:   q = wrap_inc(p, s);  // forward; code three acts the same
        endcase
        return q;
    endfunction

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    logic [2:0]          r_state;
    logic [AW-1:0]       r_sweep_cnt;
    logic                r_seed;        // sweep came from a clear word
    logic [1:0]          r_kind;
    logic [2:0]          r_fold_cnt;
    logic [SIZE_W-1:0]   r_grid_size;
    logic [COORD_W-1:0]  r_row;
    logic [COORD_W-1:0]  r_col;
    logic                r_live;
    logic                r_o_valid;

    logic [STEP_W-1:0]   r_row_step;
    logic [STEP_W-1:0]   r_col_step;
    logic [COORD_W-1:0]  r_div_row;
    logic [COORD_W-1:0]  r_div_col;
    logic [COORD_W-1:0]  r_rem_row;
    logic [COORD_W-1:0]  r_rem_col;
    logic                r_nb_up;
    logic                r_nb_dn;
    logic [STAT_W-1:0]   r_o_status;
    logic [COORD_W-1:0]  r_o_row;
    logic [COORD_W-1:0]  r_o_col;

    // -----------------------------------------------------------------------
    // Combinational
    // -----------------------------------------------------------------------
    logic [SIZE_W-1:0]   s_use;
    logic [SIZE_W-1:0]   s_m1;
    logic [COORD_W-1:0]  sat_row, sat_col;
    logic [STEP_W-1:0]   st_row, st_col;
    logic [COORD_W-1:0]  mv_row, mv_col;
    logic [COORD_W-1:0]  n_row, n_col;
    logic [COORD_W-1:0]  up_row, dn_row, col_l, col_r;
    logic [COORD_W-1:0]  seed_pos;
    logic                needs_fold;
    logic                in_acc;
    logic                launch_acc;
    logic                slot_free;
    logic                stick;
    logic                deposit;
    logic [STAT_W-1:0]   n_status;
    logic [SIZE_W-1:0]   fold_t_row, fold_t_col;
    logic [COORD_W-1:0]  n_rem_row, n_rem_col;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [SIDE_CAP-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [SIDE_CAP-1:0] ram_rd_data;
    logic [SIDE_CAP-1:0] own_bit;
    logic [SIDE_CAP-1:0] seed_word;

    // side in use: clamp to [3, SIDE_CAP]
    always_comb begin
        if (r_grid_size < MIN_S) begin
            s_use = MIN_S;
        end else if (r_grid_size > CAP_S) begin
            s_use = CAP_S;
        end else begin
            s_use = r_grid_size;
        end
    end
    assign s_m1 = s_use - SIZE_W'(1);

    assign sat_row = ({1'b0, i_launch_row} > s_m1) ? s_m1[COORD_W-1:0] : i_launch_row;
    assign sat_col = ({1'b0, i_launch_col} > s_m1) ? s_m1[COORD_W-1:0] : i_launch_col;

    // steps come straight from the port on accept, from the latch after a fold
    assign st_row = (r_state == S_IDLE) ? i_row_step : r_row_step;
    assign st_col = (r_state == S_IDLE) ? i_col_step : r_col_step;
    assign mv_row = step_pos(r_row, st_row, s_use);
    assign mv_col = step_pos(r_col, st_col, s_use);

    assign n_row = ((r_state == S_IDLE) && (i_operation == OP_LAUNCH)) ? sat_row : mv_row;
    assign n_col = ((r_state == S_IDLE) && (i_operation == OP_LAUNCH)) ? sat_col : mv_col;

    assign up_row = wrap_dec(n_row, s_use);
    assign dn_row = wrap_inc(r_row, s_use);
    assign col_l  = wrap_dec(r_col, s_use);
    assign col_r  = wrap_inc(r_col, s_use);

    // walker left outside after a size change: fold before stepping
    assign needs_fold = ({1'b0, r_row} >= s_use) || ({1'b0, r_col} >= s_use);

    // restoring remainder, one dividend bit per cycle
    assign fold_t_row = {r_rem_row, r_div_row[COORD_W-1]};
    assign fold_t_col = {r_rem_col, r_div_col[COORD_W-1]};
    assign n_rem_row  = (fold_t_row >= s_use) ? COORD_W'(fold_t_row - s_use)
                                              : fold_t_row[COORD_W-1:0];
    assign n_rem_col  = (fold_t_col >= s_use) ? COORD_W'(fold_t_col - s_use)
                                              : fold_t_col[COORD_W-1:0];

    assign o_ready    = (r_state == S_IDLE);
    assign in_acc     = i_valid && o_ready;
    assign launch_acc = in_acc && (i_operation == OP_LAUNCH);
    assign slot_free  = !r_o_valid || i_ready;

    // own row word sits on the RAM output during decide
    assign stick = r_nb_up || r_nb_dn
                || ram_rd_data[col_l[AW-1:0]] || ram_rd_data[col_r[AW-1:0]];

    // walker touches the cluster and its word can leave: mark its cell
    assign deposit = (r_state == S_DECIDE) && (r_kind == KIND_SETTLE) && stick && slot_free;

    always_comb begin
        unique case (r_kind)
            KIND_SETTLE: n_status = stick ? STAT_STUCK : STAT_WALK;
            KIND_CLEAR:  n_status = STAT_CLEAR;
            default:     n_status = STAT_IGNORE;
        endcase
    end

    assign seed_pos = s_use[COORD_W:1];

    always_comb begin
        own_bit                    = '0;
        own_bit[r_col[AW-1:0]]     = 1'b1;
        seed_word                  = '0;
        seed_word[seed_pos[AW-1:0]] = 1'b1;
    end

    // RAM port control
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_row[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                ram_rd_en   = in_acc && ((i_operation == OP_LAUNCH) ||
                              ((i_operation == OP_MOVE) && r_live && !needs_fold));
                ram_rd_addr = up_row[AW-1:0];
            end
            S_MOVE: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = up_row[AW-1:0];
            end
            S_RD_DN: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = dn_row[AW-1:0];
            end
            S_RD_OWN: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_row[AW-1:0];
            end
            default: begin
                ram_rd_en   = 1'b0;
            end
        endcase
    end

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_sweep_cnt;
        ram_wr_data = '0;
        if (r_state == S_SWEEP) begin
            ram_wr_en   = 1'b1;
            ram_wr_data = (r_seed && (r_sweep_cnt == seed_pos[AW-1:0])) ? seed_word : '0;
        end else if (deposit) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_row[AW-1:0];
            ram_wr_data = ram_rd_data | own_bit;
        end
    end

    // occupancy: one row of the torus per RAM word
    dla_ram #(
        .WIDTH (SIDE_CAP),
        .DEPTH (SIDE_CAP)
    ) u_grid (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // -----------------------------------------------------------------------
    // Control
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep_cnt <= '0;
            r_seed      <= 1'b0;
            r_kind      <= KIND_IGNORE;
            r_fold_cnt  <= '0;
            r_grid_size <= GRID_SIZE_RST;
            r_row       <= '0;
            r_col       <= '0;
            r_live      <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_grid_size <= i_cfg_wr_data;
            end
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    r_sweep_cnt <= r_sweep_cnt + AW'(1);
                    if (r_sweep_cnt == LAST_ROW) begin
                        r_sweep_cnt <= '0;
                        r_seed      <= 1'b0;
                        if (r_seed) begin
                            r_kind  <= KIND_CLEAR;
                            r_state <= S_DECIDE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        priority if (i_operation == OP_CLEAR) begin
                            r_seed  <= 1'b1;
                            r_live  <= 1'b0;
                            r_state <= S_SWEEP;
                        end else if (i_operation == OP_LAUNCH) begin
                            r_row   <= n_row;
                            r_col   <= n_col;
                            r_live  <= 1'b1;
                            r_kind  <= KIND_SETTLE;
                            r_state <= S_RD_DN;
                        end else if ((i_operation == OP_MOVE) && r_live) begin
                            r_kind <= KIND_SETTLE;
                            if (needs_fold) begin
                                r_fold_cnt <= '0;
                                r_state    <= S_FOLD;
                            end else begin
                                r_row   <= n_row;
                                r_col   <= n_col;
                                r_state <= S_RD_DN;
                            end
                        end else begin
                            r_kind  <= KIND_IGNORE;
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_FOLD: begin
                    r_fold_cnt <= r_fold_cnt + 3'd1;
                    if (r_fold_cnt == FOLD_LAST) begin
                        r_row   <= n_rem_row;
                        r_col   <= n_rem_col;
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    r_row   <= n_row;
                    r_col   <= n_col;
                    r_state <= S_RD_DN;
                end
                S_RD_DN: begin
                    r_state <= S_RD_OWN;
                end
                S_RD_OWN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (slot_free) begin
                        r_o_valid <= 1'b1;
                        if ((r_kind == KIND_SETTLE) && stick) begin
                            r_live <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Datapath (no reset)
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row_step <= i_row_step;
            r_col_step <= i_col_step;
        end
        if (r_state == S_IDLE) begin
            r_div_row <= r_row;
            r_div_col <= r_col;
            r_rem_row <= '0;
            r_rem_col <= '0;
        end else if (r_state == S_FOLD) begin
            r_div_row <= {r_div_row[COORD_W-2:0], 1'b0};
            r_div_col <= {r_div_col[COORD_W-2:0], 1'b0};
            r_rem_row <= n_rem_row;
            r_rem_col <= n_rem_col;
        end
        // up row data arrives while the down row is requested, and so on
        if (r_state == S_RD_DN) begin
            r_nb_up <= ram_rd_data[r_col[AW-1:0]];
        end
        if (r_state == S_RD_OWN) begin
            r_nb_dn <= ram_rd_data[r_col[AW-1:0]];
        end
        if ((r_state == S_DECIDE) && slot_free) begin
            r_o_status <= n_status;
            r_o_row    <= r_row;
            r_o_col    <= r_col;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_row    = r_o_row;
    assign o_col    = r_o_col;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `DLA_ASSERT_NXT(a_launch_reads, i_clk, i_rst_n, launch_acc, (r_state == S_RD_DN) && r_live)
    `DLA_ASSERT_NXT(a_stick_drops_walker, i_clk, i_rst_n, deposit, !r_live)
    `DLA_ASSERT_IMP(a_word_from_decide, i_clk, i_rst_n, $rose(r_o_valid), $past(r_state) == S_DECIDE)

endmodule

// ----- rtl/dla_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DLA generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module dla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- verif/dla_walker_grid_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DLA walker grid step checker
// Tracks the occupancy grid and walker from accepted in words and compares
// every out word, field by field, with the oldest predicted report.
// ---------------------------------------------------------------------------
module dla_walker_grid_checker
    import dla_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [SIZE_W-1:0]  i_cfg_wr_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [COORD_W-1:0] i_launch_row,
    input  logic [COORD_W-1:0] i_launch_col,
    input  logic [STEP_W-1:0]  i_row_step,
    input  logic [STEP_W-1:0]  i_col_step,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [STAT_W-1:0]  i_status,
    input  logic [COORD_W-1:0] i_row,
    input  logic [COORD_W-1:0] i_col,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int MIN_SIDE = 3;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_walker_report;

    bit                 occ [MAX_SIDE_DEF*MAX_SIDE_DEF];
    logic [SIZE_W-1:0]  size_reg;
    logic [COORD_W-1:0] wk_row;
    logic [COORD_W-1:0] wk_col;
    bit                 wk_live;
    t_walker_report     pending_reports [$];
    int                 mismatch_cnt = 0;

    function automatic int side_now();
        int s;
        s = int'(size_reg);
        if (s < MIN_SIDE) s = MIN_SIDE;
        if (s > MAX_SIDE_DEF) s = MAX_SIDE_DEF;
        if (s > SIDE_LIMIT) s = SIDE_LIMIT;
        return s;
    endfunction

    function automatic bit occupied(int r, int c);
        return occ[r*MAX_SIDE_DEF + c];
    endfunction

    function automatic logic [COORD_W-1:0] wrap_step(logic [COORD_W-1:0] pos,
                                                     logic [STEP_W-1:0] step, int s);
        int d;
        case (step)
            STEP_BACK: d = s - 1;
            STEP_STAY: d = 0;
            default:   d = 1;     // forward, and the spare code too
        endcase
        return COORD_W'((int'(pos) % s + d) % s);
    endfunction

    // neighbour test on the torus; deposit on contact
    function automatic logic [STAT_W-1:0] settle(int s);
        int r;
        int c;
        bit hit;
        r = int'(wk_row);
        c = int'(wk_col);
        hit = occupied(r, (c + 1) % s) || occupied(r, (c + s - 1) % s) ||
              occupied((r + 1) % s, c) || occupied((r + s - 1) % s, c);
        if (hit) begin
            occ[r*MAX_SIDE_DEF + c] = 1'b1;
            wk_live = 1'b0;
            return STAT_STUCK;
        end
        return STAT_WALK;
    endfunction

    function automatic t_walker_report advance_walker(logic [OP_W-1:0] op,
                                                      logic [COORD_W-1:0] lr,
                                                      logic [COORD_W-1:0] lc,
                                                      logic [STEP_W-1:0] rs,
                                                      logic [STEP_W-1:0] cs);
        int s;
        t_walker_report rep;
        s = side_now();
        rep.status = STAT_IGNORE;
        case (op)
            OP_CLEAR: begin
                occ = '{default: 1'b0};
                occ[(s/2)*MAX_SIDE_DEF + s/2] = 1'b1;
                wk_live    = 1'b0;
                rep.status = STAT_CLEAR;
            end
            OP_LAUNCH: begin
                wk_row     = (int'(lr) > s - 1) ? COORD_W'(s - 1) : lr;
                wk_col     = (int'(lc) > s - 1) ? COORD_W'(s - 1) : lc;
                wk_live    = 1'b1;
                rep.status = settle(s);
            end
            OP_MOVE: begin
                if (wk_live) begin
                    wk_row     = wrap_step(wk_row, rs, s);
                    wk_col     = wrap_step(wk_col, cs, s);
                    rep.status = settle(s);
                end
            end
            default: ;
        endcase
        rep.row = wk_row;
        rep.col = wk_col;
        return rep;
    endfunction

    task automatic compare_field(string name, logic [COORD_W-1:0] want,
                                 logic [COORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: out word %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_walker_report got;
        t_walker_report want;
        if (!i_rst_n) begin
            occ      = '{default: 1'b0};
            size_reg = GRID_SIZE_RST;
            wk_row   = '0;
            wk_col   = '0;
            wk_live  = 1'b0;
            pending_reports.delete();
        end else begin
            if (i_cfg_wr_en) size_reg = i_cfg_wr_data;
            if (i_out_valid && i_out_ready) begin
                got = {i_status, i_row, i_col};
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected out word, status %0d row %0d col %0d",
                             $time, got.status, got.row, got.col);
                    mismatch_cnt++;
                end else begin
                    want = pending_reports.pop_front();
                    compare_field("status", COORD_W'(want.status), COORD_W'(got.status));
                    compare_field("row", want.row, got.row);
                    compare_field("col", want.col, got.col);
                end
            end
            if (i_in_valid && i_in_ready)
                pending_reports.push_back(advance_walker(i_operation, i_launch_row,
                                                         i_launch_col, i_row_step,
                                                         i_col_step));
        end
        o_errors  <= mismatch_cnt;
        o_pending <= pending_reports.size();
    end

endmodule

// ----- verif/tb_dla_walker_grid_step.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DLA walker grid step testbench
// Directed corner words, then segments of launch/move walks with random
// content over many grid sizes and idle mixes; a side checker predicts
// and compares every out word.
// ---------------------------------------------------------------------------
module tb_dla_walker_grid_step;
    import dla_pkg::*;

    // codes the package leaves unnamed
    localparam logic [OP_W-1:0]   OP_NOP   = 2'd3;
    localparam logic [STEP_W-1:0] STEP_FWD = 2'd2;
    localparam logic [STEP_W-1:0] STEP_ODD = 2'd3;   // decodes as forward

    localparam int MIN_SIDE      = 3;
    localparam int SEG_WORDS     = 32;    // fewest words in a random segment
    localparam int RANDOM_TARGET = 475;   // fewest in words sent in the random part
    localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
    localparam int MAX_MOVES     = 12;    // longest walk after a launch
    localparam int NEAR_SEED     = 6;     // launch window around the seed

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // config port
    logic              cfg_wr_en   = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = '0;

    // in word
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    operation  = OP_NOP;
    logic [COORD_W-1:0] launch_row = '0;
    logic [COORD_W-1:0] launch_col = '0;
    logic [STEP_W-1:0]  row_step   = STEP_STAY;
    logic [STEP_W-1:0]  col_step   = STEP_STAY;

    // out word
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [STAT_W-1:0]  res_status;
    logic [COORD_W-1:0] res_row;
    logic [COORD_W-1:0] res_col;

    // checker handoff
    int errors;
    int pending;

    // idle mix, set by the stimulus between segments only
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // hold-off requests: stimulus bumps hold_reqs, receiver owns the count
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    dla_walker_grid_step u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_operation   (operation),
        .i_launch_row  (launch_row),
        .i_launch_col  (launch_col),
        .i_row_step    (row_step),
        .i_col_step    (col_step),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_status      (res_status),
        .o_row         (res_row),
        .o_col         (res_col)
    );

    dla_walker_grid_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_operation   (operation),
        .i_launch_row  (launch_row),
        .i_launch_col  (launch_col),
        .i_row_step    (row_step),
        .i_col_step    (col_step),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (res_status),
        .i_row         (res_row),
        .i_col         (res_col),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    // Receiver: random stalls, or a long hold-off while one is requested.
    always @(negedge clk) begin : rx_side
        if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one word. Called just after a falling edge, returns just after
    // the falling edge that follows acceptance. Valid stays high when words
    // come back to back; it only drops for a sender gap or a drain.
    task automatic send_word(logic [OP_W-1:0] op, logic [COORD_W-1:0] lr,
                             logic [COORD_W-1:0] lc, logic [STEP_W-1:0] rs,
                             logic [STEP_W-1:0] cs);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        launch_row <= lr;
        launch_col <= lc;
        row_step   <= rs;
        col_step   <= cs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Sender pause: nothing offered until every expected word is back.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    // Grid size is only touched with the block idle.
    task automatic set_size(logic [SIZE_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stimulus
        int seg;
        int sent;
        int total;
        int moves;
        int span;
        int reach;
        int mid;
        int size_plan [16];
        logic [COORD_W-1:0] lr;
        logic [COORD_W-1:0] lc;

        // sizes per segment: both extremes, odd and even, out of range
        size_plan = '{5, 3, 8, 256, 11, 0, 16, 4, 300, 7, 2, 9, 511, 6, 13, 3};

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // block runs a clearing pass with o_ready low after reset
        @(negedge clk);
        while (!in_ready) @(negedge clk);

        // ---------------- directed corners, full 256 side ----------------
        set_size(GRID_SIZE_RST);
        send_word(OP_MOVE, 8'd0, 8'd0, STEP_FWD, STEP_FWD);      // no live walker
        send_word(OP_NOP, 8'd255, 8'd255, STEP_ODD, STEP_ODD);   // unused op
        send_word(OP_CLEAR, 8'd0, 8'd0, STEP_STAY, STEP_STAY);   // seed at 128,128
        send_word(OP_LAUNCH, 8'd255, 8'd255, STEP_STAY, STEP_STAY);
        send_word(OP_MOVE, 8'd0, 8'd0, STEP_ODD, STEP_ODD);      // wraps to 0,0
        send_word(OP_MOVE, 8'd0, 8'd0, STEP_BACK, STEP_BACK);    // wraps back
        send_word(OP_LAUNCH, 8'd128, 8'd127, STEP_STAY, STEP_STAY);  // sticks
        send_word(OP_LAUNCH, 8'd10, 8'd10, STEP_STAY, STEP_STAY);
        send_word(OP_LAUNCH, 8'd127, 8'd127, STEP_STAY, STEP_STAY);  // replaces live
        send_word(OP_LAUNCH, 8'd128, 8'd128, STEP_STAY, STEP_STAY);  // on occupied
        send_word(OP_LAUNCH, 8'd50, 8'd60, STEP_STAY, STEP_STAY);
        send_word(OP_CLEAR, 8'd0, 8'd0, STEP_STAY, STEP_STAY);   // position kept
        send_word(OP_MOVE, 8'd0, 8'd0, STEP_FWD, STEP_BACK);     // walker gone
        send_word(OP_LAUNCH, 8'd200, 8'd201, STEP_STAY, STEP_STAY);

        // shrink with a live walker outside the new square, no clear
        set_size(9'd5);
        send_word(OP_MOVE, 8'd0, 8'd0, STEP_STAY, STEP_STAY);    // folded first
        send_word(OP_CLEAR, 8'd0, 8'd0, STEP_STAY, STEP_STAY);   // seed at 2,2
        send_word(OP_LAUNCH, 8'd2, 8'd3, STEP_STAY, STEP_STAY);
        send_word(OP_LAUNCH, 8'd255, 8'd0, STEP_STAY, STEP_STAY);    // saturates
        send_word(OP_MOVE, 8'd0, 8'd0, STEP_BACK, STEP_FWD);

        // below the minimum: clamps to a 3 by 3 grid
        set_size(9'd0);
        send_word(OP_CLEAR, 8'd0, 8'd0, STEP_STAY, STEP_STAY);
        send_word(OP_LAUNCH, 8'd0, 8'd0, STEP_STAY, STEP_STAY);
        send_word(OP_MOVE, 8'd0, 8'd0, STEP_FWD, STEP_STAY);

        // above the maximum, grown back without a clear
        set_size(9'd511);
        send_word(OP_LAUNCH, 8'd255, 8'd255, STEP_STAY, STEP_STAY);
        send_word(OP_MOVE, 8'd0, 8'd0, STEP_ODD, STEP_BACK);
        send_word(OP_LAUNCH, 8'd0, 8'd1, STEP_STAY, STEP_STAY);

        // ---------------- random walks ----------------
        // Idle mix rotates per segment; every third segment keeps the old
        // grid across the resize instead of clearing.
        total = 0;
        seg   = 0;
        while (total < RANDOM_TARGET) begin
            set_size(SIZE_W'(size_plan[seg % 16]));
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase

            span = size_plan[seg % 16];
            if (span < MIN_SIDE) span = MIN_SIDE;
            if (span > SIDE_LIMIT) span = SIDE_LIMIT;
            mid   = span / 2;
            reach = (mid < NEAR_SEED) ? mid : NEAR_SEED;

            sent = 0;
            if (seg % 3 != 2) begin
                send_word(OP_CLEAR, 8'd0, 8'd0, STEP_STAY, STEP_STAY);
                sent++;
            end

            // long receiver hold-off with the sender pushing flat out:
            // the block fills and drops o_ready
            if (seg == 2) hold_reqs++;

            while (sent < SEG_WORDS) begin
                if ($urandom_range(99) < 8) begin
                    // noise: any op, any fields
                    send_word(OP_W'($urandom_range(3)), COORD_W'($urandom),
                              COORD_W'($urandom), STEP_W'($urandom_range(3)),
                              STEP_W'($urandom_range(3)));
                    sent++;
                end else begin
                    // launch near the seed, sometimes anywhere, then a walk
                    if ($urandom_range(9) == 0) begin
                        lr = COORD_W'($urandom);
                        lc = COORD_W'($urandom);
                    end else begin
                        lr = COORD_W'(mid - reach + $urandom_range(2*reach));
                        lc = COORD_W'(mid - reach + $urandom_range(2*reach));
                    end
                    send_word(OP_LAUNCH, lr, lc, STEP_W'($urandom_range(3)),
                              STEP_W'($urandom_range(3)));
                    sent++;
                    moves = $urandom_range(MAX_MOVES, 1);
                    repeat (moves) begin
                        send_word(OP_MOVE, COORD_W'($urandom), COORD_W'($urandom),
                                  STEP_W'($urandom_range(3)), STEP_W'($urandom_range(3)));
                        sent++;
                    end
                end
            end
            total += sent;
            seg++;
        end

        // wind down: everything back, then a margin for stray words
        drain();
        repeat (32) @(posedge clk);
        if (errors == 0)
            $display("** dla_walker_grid_step: PASSED **");
        else
            $display("** dla_walker_grid_step: FAILED **");
        $finish;
    end

    // 5 ms: far beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("** dla_walker_grid_step: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dla_pkg.sv
rtl/dla_ram.sv
rtl/dla_walker_grid_step.sv
verif/dla_walker_grid_checker.sv
verif/tb_dla_walker_grid_step.sv
